### rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none
package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_SEND  = 3'd2,
        OP_RECV  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } op_t;

    localparam int unsigned BIT_COUNT = 8;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned PHASE_W   = 2;
    localparam logic [STEP_W-1:0] SEND_LAST = STEP_W'(3 * BIT_COUNT - 1);
    localparam logic [STEP_W-1:0] RECV_LAST = STEP_W'(2 * BIT_COUNT);
    localparam logic [PHASE_W-1:0] PHASE_DRIVE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_HIGH  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LOW   = 2'd2;

    typedef struct packed {
        logic       is_tick;
        logic       op_ok;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } result_t;

endpackage
`default_nettype wire

### rtl/i2cm_fifo.sv
// Small register FIFO with push/full and pop/empty sides.
`default_nettype none
module i2cm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

### rtl/i2cm_front.sv
// Front end: classify incoming transactions and queue them for the pin sequencer.
`default_nettype none
module i2cm_front #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          kind,
    input  wire logic [2:0]    op,
    input  wire logic [7:0]    tx_byte,
    input  wire logic          ack_out,
    input  wire logic          sda_in,
    output i2cm_pkg::item_t    item,
    output logic               item_valid,
    input  wire logic          item_take
);
    i2cm_pkg::item_t in_item;
    logic            q_empty;

    always_comb
    begin
        in_item.is_tick = kind;
        in_item.op_ok   = (op <= 3'(i2cm_pkg::OP_RACK));
        in_item.op      = op;
        in_item.tx_byte = tx_byte;
        in_item.ack_out = ack_out;
        in_item.sda_in  = sda_in;
    end

    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_item),
        .full  (full),
        .pop   (item_take),
        .rdata (item),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;
endmodule
`default_nettype wire

### rtl/i2cm_back.sv
// Back end: run the pin programs one step per tick and build each result.
`default_nettype none
module i2cm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire i2cm_pkg::item_t  item,
    input  wire logic             item_valid,
    output logic                  item_take,
    input  wire logic             res_full,
    output logic                  res_push,
    output i2cm_pkg::result_t     res
);
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    i2cm_pkg::op_t                op_reg, op_next;
    logic [i2cm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [i2cm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         busy_reg, busy_next;
    logic [7:0]                   tx_reg, tx_next;
    logic [7:0]                   rx_reg, rx_next;
    logic                         ack_hold_reg, ack_hold_next;
    logic                         ack_read_reg, ack_read_next;
    logic                         done, rej, last;

    assign item_take = item_valid && !res_full;
    assign res_push  = item_take;

    always_comb
    begin
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        busy_next     = busy_reg;
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        ack_hold_next = ack_hold_reg;
        ack_read_next = ack_read_reg;
        done          = 1'b0;
        rej           = 1'b0;
        last          = 1'b0;
        if (!item.is_tick)
        begin
            if (busy_reg || !item.op_ok)
            begin
                rej = 1'b1;
            end
            else
            begin
                op_next    = i2cm_pkg::op_t'(item.op);
                step_next  = '0;
                phase_next = i2cm_pkg::PHASE_DRIVE;
                busy_next  = 1'b1;
                if (item.op == 3'(i2cm_pkg::OP_SEND))
                begin
                    tx_next = item.tx_byte;
                end
                if (item.op == 3'(i2cm_pkg::OP_SACK))
                begin
                    ack_hold_next = item.ack_out;
                end
            end
        end
        else if (busy_reg)
        begin
            case (op_reg)
                i2cm_pkg::OP_START:
                begin
                    case (step_reg)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default:
                        begin
                            scl_next = 1'b0;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::OP_STOP:
                begin
                    case (step_reg)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default:
                        begin
                            sda_next = 1'b1;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::OP_SEND:
                begin
                    case (phase_reg)
                        i2cm_pkg::PHASE_DRIVE:
                        begin
                            sda_next = tx_reg[7];
                            tx_next  = {tx_reg[6:0], 1'b0};
                        end
                        i2cm_pkg::PHASE_HIGH: scl_next = 1'b1;
                        default:
                        begin
                            scl_next = 1'b0;
                            last     = (step_reg >= i2cm_pkg::SEND_LAST);
                        end
                    endcase
                end
                i2cm_pkg::OP_RECV:
                begin
                    if (step_reg == '0)
                    begin
                        sda_next = 1'b1;
                        tx_next  = '0;
                    end
                    else if (step_reg[0])
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        tx_next  = {tx_reg[6:0], item.sda_in};
                        scl_next = 1'b0;
                        if (step_reg >= i2cm_pkg::RECV_LAST)
                        begin
                            rx_next = {tx_reg[6:0], item.sda_in};
                            last    = 1'b1;
                        end
                    end
                end
                i2cm_pkg::OP_SACK:
                begin
                    case (step_reg)
                        5'd0:    sda_next = ack_hold_reg;
                        5'd1:    scl_next = 1'b1;
                        default:
                        begin
                            scl_next = 1'b0;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::OP_RACK:
                begin
                    case (step_reg)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        default:
                        begin
                            ack_read_next = item.sda_in;
                            scl_next      = 1'b0;
                            last          = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase
            done = last;
            if (last)
            begin
                busy_next  = 1'b0;
                step_next  = '0;
                phase_next = i2cm_pkg::PHASE_DRIVE;
            end
            else
            begin
                step_next  = step_reg + 1'b1;
                phase_next = (phase_reg == i2cm_pkg::PHASE_LOW) ? i2cm_pkg::PHASE_DRIVE
                                                                 : phase_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        res.scl_level = scl_next;
        res.sda_level = sda_next;
        res.busy_res  = busy_next;
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.ack_seen  = ack_read_next;
        res.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            op_reg       <= i2cm_pkg::OP_START;
            step_reg     <= '0;
            phase_reg    <= i2cm_pkg::PHASE_DRIVE;
            busy_reg     <= 1'b0;
            tx_reg       <= '0;
            rx_reg       <= '0;
            ack_hold_reg <= 1'b0;
            ack_read_reg <= 1'b0;
        end
        else if (item_take)
        begin
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            op_reg       <= op_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            busy_reg     <= busy_next;
            tx_reg       <= tx_next;
            rx_reg       <= rx_next;
            ack_hold_reg <= ack_hold_next;
            ack_read_reg <= ack_read_next;
        end
    end
endmodule
`default_nettype wire

### rtl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer.
// A transaction's result passes through the input queue and then the result queue
// before it is on the result ports, where it can be popped.
// Throughput: one transaction per cycle, retired by the pin sequencer unless the result queue is full.
// Reset: both lines released, sequencer idle, both queues empty.
`default_nettype none
module i2c_master_bit_sequencer #(
    parameter int unsigned IN_DEPTH  = 2,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       kind,
    input  wire logic [2:0] op,
    input  wire logic [7:0] tx_byte,
    input  wire logic       ack_out,
    input  wire logic       sda_in,
    output logic            empty,
    input  wire logic       pop,
    output logic            scl_level,
    output logic            sda_level,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      rx_byte,
    output logic            ack_seen,
    output logic            rejected
);
    i2cm_pkg::item_t   item;
    logic              item_valid;
    logic              item_take;
    i2cm_pkg::result_t res_in;
    i2cm_pkg::result_t res_out;
    logic              res_push;
    logic              res_full;

    i2cm_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .op         (op),
        .tx_byte    (tx_byte),
        .ack_out    (ack_out),
        .sda_in     (sda_in),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign scl_level = res_out.scl_level;
    assign sda_level = res_out.sda_level;
    assign busy_res  = res_out.busy_res;
    assign done_res  = res_out.done_res;
    assign rx_byte   = res_out.rx_byte;
    assign ack_seen  = res_out.ack_seen;
    assign rejected  = res_out.rejected;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.done_res) |-> !res_in.busy_res)
        else $error("finished transaction still reports busy");

    a_rej_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.rejected) |-> !res_in.done_res)
        else $error("rejected command also reports done");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> !res_full)
        else $error("result pushed into a full queue");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("sequencer took from an empty input queue");
endmodule
`default_nettype wire
